// ===== sv/md4_pkg.sv =====
package md4_pkg;

  localparam logic [31:0] K2 = 32'o13240474631;
  localparam logic [31:0] K3 = 32'o15666365641;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;
  localparam logic [1:0] RND_H = 2'd2;

  localparam logic [5:0] LAST_STEP = 6'd47;
  localparam logic [5:0] LEN_POS   = 6'd56;

  typedef struct packed {
    logic       en;
    logic [5:0] pos;
    logic [7:0] data;
  } buf_wr_t;

  function automatic logic [4:0] shift_amt(input logic [1:0] rnd, input logic [1:0] sub);
    logic [4:0] s;
    s = 5'd3;
    case (rnd)
      RND_F: begin
        case (sub)
          2'd0: s = 5'd3;
          2'd1: s = 5'd7;
          2'd2: s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      RND_G: begin
        case (sub)
          2'd0: s = 5'd3;
          2'd1: s = 5'd5;
          2'd2: s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (sub)
          2'd0: s = 5'd3;
          2'd1: s = 5'd9;
          2'd2: s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  // message word used by a step: straight, transposed, then bit-reversed
  function automatic logic [3:0] word_idx(input logic [1:0] rnd, input logic [3:0] k);
    logic [3:0] w;
    case (rnd)
      RND_F:   w = k;
      RND_G:   w = {k[1:0], k[3:2]};
      default: w = {k[0], k[1], k[2], k[3]};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/md4_block_buf.sv =====
module md4_block_buf (
  input  logic             clk,
  input  md4_pkg::buf_wr_t wr,
  input  logic [3:0]       rd_idx,
  output logic [31:0]      rd_word
);
  import md4_pkg::*;

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.pos[5:2]][{wr.pos[1:0], 3'b000} +: 8] <= wr.data;
    end
    rd_word <= mem[rd_idx];
  end

endmodule

// ===== sv/md4_step_unit.sv =====
module md4_step_unit (
  input  logic [1:0]  rnd,
  input  logic [4:0]  shamt,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] x,
  output logic [31:0] result
);
  import md4_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] sum;
  logic [63:0] rot;

  always_comb begin
    case (rnd)
      RND_F: begin
        f = (b & c) | (~b & d);
        k = 32'd0;
      end
      RND_G: begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end
      default: begin
        f = b ^ c ^ d;
        k = K3;
      end
    endcase
  end

  assign sum    = a + f + x + k;
  assign rot    = {sum, sum} << shamt;
  assign result = rot[63:32];

endmodule

// ===== sv/md4_digest_stream.sv =====
// MD4 digest of a byte stream. Each accepted beat may carry one message byte
// (byte_valid) and may end the message (last). The 64th byte of a block starts
// a compression (load, 48 steps on one shared step unit, chain add) during
// which in_stall is high. At the end of a message the padding, the 0x80 byte,
// zeros and the 64-bit bit length, is written one byte per cycle up to the end
// of the block, then compressed; this happens once, or twice when fewer than 9
// bytes were free. The digest sits in an output register, so the next message
// can start while it waits to be taken.
module md4_digest_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_a,
  output logic [31:0] digest_b,
  output logic [31:0] digest_c,
  output logic [31:0] digest_d
);
  import md4_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_PAD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [5:0]  step;
  logic        pend_last;
  logic        padding;
  logic        pad_first;
  logic        final_blk;
  logic [31:0] ch_a, ch_b, ch_c, ch_d;
  logic [31:0] ra, rb, rc, rd;

  buf_wr_t     wr;
  logic [31:0] x_word;
  logic [31:0] step_out;
  logic [1:0]  rnd;
  logic [7:0]  pad_data;
  logic        accept;
  logic [5:0]  fill_next;
  logic [5:0]  rd_step;
  logic        post_digest;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign rnd      = step[5:4];

  // fetch the word in the cycle before the step that uses it (the read is registered)
  assign rd_step  = (state == S_STEP) ? step + 6'd1 : 6'd0;

  assign post_digest = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    if (pad_first) begin
      pad_data = PAD_BYTE;
    end else if (final_blk && fill >= LEN_POS) begin
      pad_data = bit_len[{fill[2:0], 3'b000} +: 8];
    end else begin
      pad_data = 8'h00;
    end
  end

  always_comb begin
    wr.en   = 1'b0;
    wr.pos  = fill;
    wr.data = data_byte;
    if (accept && byte_valid) begin
      wr.en = 1'b1;
    end else if (state == S_PAD) begin
      wr.en   = 1'b1;
      wr.data = pad_data;
    end
  end

  assign fill_next = (accept && byte_valid) ? fill + 6'd1 : fill;

  md4_block_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_idx  (word_idx(rd_step[5:4], rd_step[3:0])),
    .rd_word (x_word)
  );

  md4_step_unit u_step (
    .rnd    (rnd),
    .shamt  (shift_amt(rnd, step[1:0])),
    .a      (ra),
    .b      (rb),
    .c      (rc),
    .d      (rd),
    .x      (x_word),
    .result (step_out)
  );

  // working registers rotate so the unit always reads the first slot and writes the second
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      ra <= ch_a;
      rb <= ch_b;
      rc <= ch_c;
      rd <= ch_d;
    end else if (state == S_STEP) begin
      ra <= rd;
      rb <= step_out;
      rc <= rb;
      rd <= rc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= 6'd0;
      bit_len   <= 64'd0;
      step      <= 6'd0;
      pend_last <= 1'b0;
      padding   <= 1'b0;
      pad_first <= 1'b0;
      final_blk <= 1'b0;
      out_valid <= 1'b0;
      ch_a      <= INIT_A;
      ch_b      <= INIT_B;
      ch_c      <= INIT_C;
      ch_d      <= INIT_D;
    end else begin
      if (post_digest) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            fill      <= fill_next;
            pend_last <= last;
            if (byte_valid) begin
              bit_len <= bit_len + 64'd8;
            end
            if (byte_valid && fill == 6'd63) begin
              state <= S_LOAD;
            end else if (last) begin
              state     <= S_PAD;
              padding   <= 1'b1;
              pad_first <= 1'b1;
              final_blk <= (fill_next < LEN_POS);
            end
          end
        end
        S_LOAD: begin
          step  <= 6'd0;
          state <= S_STEP;
        end
        S_STEP: begin
          step <= step + 6'd1;
          if (step == LAST_STEP) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          ch_a <= ch_a + ra;
          ch_b <= ch_b + rb;
          ch_c <= ch_c + rc;
          ch_d <= ch_d + rd;
          if (padding) begin
            if (final_blk) begin
              state <= S_DONE;
            end else begin
              state     <= S_PAD;
              final_blk <= 1'b1;
            end
          end else if (pend_last) begin
            state     <= S_PAD;
            padding   <= 1'b1;
            pad_first <= 1'b1;
            final_blk <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          fill      <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_LOAD;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (post_digest) begin
            digest_a  <= ch_a;
            digest_b  <= ch_b;
            digest_c  <= ch_c;
            digest_d  <= ch_d;
            ch_a      <= INIT_A;
            ch_b      <= INIT_B;
            ch_c      <= INIT_C;
            ch_d      <= INIT_D;
            fill      <= 6'd0;
            bit_len   <= 64'd0;
            padding   <= 1'b0;
            pend_last <= 1'b0;
            final_blk <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_md4_digest_stream.sv =====
`timescale 1ns / 100ps

module tb_md4_digest_stream;
  import md4_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_vld;
    logic       eom;
  } beat_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  md4_digest_stream u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digest_a   (digest_a),
    .digest_b   (digest_b),
    .digest_c   (digest_c),
    .digest_d   (digest_d)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_t   pending_beats[$];
  digest_t digest_q[$];
  int      errors = 0;
  int      counted = 0;

  // shared idling control
  logic        calm = 1'b0;
  logic [2:0]  idle_rate = 3'd2;
  logic [7:0]  cyc = 8'd0;

  // predictor state
  logic [31:0] chain_w [4];
  logic [31:0] blk_w [16];
  logic [5:0]  fill_n;
  logic [63:0] len_bits;

  function automatic int rot_amount(input logic [1:0] rnd, input int s);
    case (rnd)
      RND_F:   case (s) 0: return 3;  1: return 7;  2: return 11; default: return 19; endcase
      RND_G:   case (s) 0: return 3;  1: return 5;  2: return 9;  default: return 13; endcase
      default: case (s) 0: return 3;  1: return 9;  2: return 11; default: return 15; endcase
    endcase
  endfunction

  task automatic chain_restart();
    chain_w[0] = INIT_A;
    chain_w[1] = INIT_B;
    chain_w[2] = INIT_C;
    chain_w[3] = INIT_D;
    fill_n = '0;
    len_bits = '0;
  endtask

  task automatic md4_compress();
    logic [31:0] r [4];
    logic [31:0] b, c, d, f, add, sum;
    logic [3:0]  k, w;
    logic [1:0]  rnd;
    int          t, rot;
    for (int i = 0; i < 4; i++) r[i] = chain_w[i];
    for (int j = 0; j < 48; j++) begin
      rnd = 2'(j / 16);
      k = 4'(j % 16);
      t = (4 - j % 4) % 4;
      b = r[(t + 1) % 4];
      c = r[(t + 2) % 4];
      d = r[(t + 3) % 4];
      case (rnd)
        RND_F: begin
          w = k;
          f = (b & c) | (~b & d);
          add = '0;
        end
        RND_G: begin
          w = {k[1:0], k[3:2]};
          f = (b & c) | (b & d) | (c & d);
          add = K2;
        end
        default: begin
          w = {k[0], k[1], k[2], k[3]};
          f = b ^ c ^ d;
          add = K3;
        end
      endcase
      rot = rot_amount(rnd, j % 4);
      sum = r[t] + f + blk_w[w] + add;
      r[t] = (sum << rot) | (sum >> (32 - rot));
    end
    for (int i = 0; i < 4; i++) chain_w[i] = chain_w[i] + r[i];
  endtask

  task automatic blk_put(input int pos, input logic [7:0] v);
    blk_w[pos / 4][8 * (pos % 4) +: 8] = v;
  endtask

  // advance the predictor by one accepted beat; queue a digest on end of message
  task automatic md4_take(input beat_t bt);
    if (bt.byte_vld) begin
      blk_put(int'(fill_n), bt.data);
      len_bits = len_bits + 64'd8;
      fill_n = fill_n + 6'd1;
      if (fill_n == 6'd0) md4_compress();
    end
    if (bt.eom) begin
      blk_put(int'(fill_n), PAD_BYTE);
      for (int p = int'(fill_n) + 1; p < 64; p++) blk_put(p, 8'h00);
      if (fill_n >= LEN_POS) begin
        md4_compress();
        for (int i = 0; i < 16; i++) blk_w[i] = '0;
      end
      blk_w[14] = len_bits[31:0];
      blk_w[15] = len_bits[63:32];
      md4_compress();
      digest_q.push_back({chain_w[0], chain_w[1], chain_w[2], chain_w[3]});
      chain_restart();
    end
  endtask

  task automatic add_beat(input logic [7:0] d, input logic bv, input logic eom);
    pending_beats.push_back(beat_t'{data: d, byte_vld: bv, eom: eom});
    counted++;
  endtask

  // message of len random bytes, with filler beats sprinkled in;
  // end on the last byte or on a separate byte-less beat
  task automatic add_message(input int len);
    logic on_byte;
    on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_beat(8'($urandom_range(0, 255)), 1'b1, on_byte && (i == len - 1));
    end
    if (!on_byte) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic int pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 20);
    if (sel < 8) begin
      case ($urandom_range(0, 9))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        7: return 120;
        8: return 127;
        default: return 128;
      endcase
    end
    return $urandom_range(0, 140);
  endfunction

  function automatic void check_word(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  // driver
  beat_t cur_beat;
  int    in_hold = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      cyc <= cyc + 8'd1;
      if (cyc == 8'd0) idle_rate <= 3'($urandom_range(0, 4));
      calm <= (pending_beats.size() < 120);
      if (in_valid && !in_stall) md4_take(cur_beat);
      if (!in_valid || !in_stall) begin
        if (in_hold != 0) begin
          in_hold--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && idle_rate != 0 && $urandom_range(1, 16) <= idle_rate) begin
          in_hold = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          cur_beat = pending_beats.pop_front();
          data_byte <= cur_beat.data;
          byte_valid <= cur_beat.byte_vld;
          last <= cur_beat.eom;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  int      out_hold = 0;
  digest_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest %h %h %h %h", digest_a, digest_b, digest_c, digest_d);
          errors++;
        end else begin
          want = digest_q.pop_front();
          check_word("digest_a", want.a, digest_a);
          check_word("digest_b", want.b, digest_b);
          check_word("digest_c", want.c, digest_c);
          check_word("digest_d", want.d, digest_d);
        end
      end
      if (out_hold != 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if (!calm && idle_rate != 0 && $urandom_range(1, 16) <= idle_rate) begin
        out_hold = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    chain_restart();
    for (int i = 0; i < 16; i++) blk_w[i] = '0;

    // empty message
    add_beat(8'h5a, 1'b0, 1'b1);
    // filler beat, then a one-byte message ending on its byte
    add_beat(8'hff, 1'b0, 1'b0);
    add_beat(8'h00, 1'b1, 1'b1);
    add_beat(8'hff, 1'b1, 1'b1);
    // bytes then a byte-less end, with a filler beat in between
    add_beat(8'hff, 1'b1, 1'b0);
    add_beat(8'h80, 1'b1, 1'b0);
    add_beat(8'h55, 1'b0, 1'b0);
    add_beat(8'haa, 1'b0, 1'b1);
    // "abc"
    add_beat(8'h61, 1'b1, 1'b0);
    add_beat(8'h62, 1'b1, 1'b0);
    add_beat(8'h63, 1'b1, 1'b1);
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h7f, 1'b1, 1'b0);
    add_beat(8'h01, 1'b1, 1'b1);

    while (counted < 1550) add_message(pick_len());

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("md4_digest_stream: match");
    end else begin
      $display("md4_digest_stream: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("md4_digest_stream: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
sv/md4_pkg.sv
sv/md4_block_buf.sv
sv/md4_step_unit.sv
sv/md4_digest_stream.sv
tb/sv/tb_md4_digest_stream.sv
